// ===== src/hmb_pkg.sv =====
// Package: shared types and constants of the horizontal motion blur core.
package hmb_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixelW = 3 * ChanW;
  localparam int unsigned LenW   = 6;
  localparam int unsigned QuotW  = 8;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

endpackage

// ===== src/hmb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hmb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/horizontal_motion_blur_core.sv =====
// Top level: forward horizontal box blur over a raster RGB pixel stream.
//
// Channel   | dir | payload
// s_axis    | in  | tdata = red, green, blue (8 bits each, red lowest); tlast = row end
// m_axis    | out | tdata = red, green, blue means (red lowest); tlast = row last
// cfg       | in  | cfg_wdata_i = blur length (6 bits), written when cfg_we_i is high
//
// Each input item is appended to the window store as it is accepted and then
// checked for whether a pixel is due. Each emitted item then takes a store
// read, the shared restoring divider (one quotient bit per cycle, eight
// quotient bits, three channels side by side) and a load of the output
// register. Reset clears the sums, counters and
// state; the window store needs no clearing since only held entries are read.
// A stalled m_axis holds the result in the output register and the engine waits.
module horizontal_motion_blur_core #(
  parameter int unsigned MAX_BLUR = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tlast,  // row end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tlast,  // row last
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_BLUR);
  localparam int unsigned CW = $clog2(MAX_BLUR + 1);
  localparam int unsigned SW = hmb_pkg::ChanW + CW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [hmb_pkg::LenW-1:0] blur_q;
  logic [SW-1:0] rsum_q, gsum_q, bsum_q;
  logic [CW-1:0] held_q;
  logic [AW-1:0] oldest_q;
  logic          flush_q;

  // divider state
  logic [SW-1:0] rrem_q, grem_q, brem_q;
  logic [hmb_pkg::QuotW-1:0] rquo_q, gquo_q, bquo_q;
  logic [CW-1:0] divisor_q;
  logic [2:0]    bit_q;
  hmb_pkg::pixel_t old_px_q;

  // output register
  logic          ovalid_q;
  hmb_pkg::pixel_t odata_q;
  logic          olast_q;

  hmb_pkg::pixel_t in_px, rd_px;
  logic [CW-1:0] eff_len;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] wr_slot;
  logic          in_acc, due, rd_en, emit_go;
  logic [SW-1:0] dshift;

  assign in_px = hmb_pkg::pixel_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Clamp length: zero acts as one, above MAX_BLUR saturates.
  always_comb begin
    if (blur_q == '0) begin
      eff_len = CW'(1);
    end else if ({1'b0, blur_q} > 7'(MAX_BLUR)) begin
      eff_len = CW'(MAX_BLUR);
    end else begin
      eff_len = CW'(blur_q);
    end
  end

  // Append slot wraps around the circular store.
  assign slot_sum = (AW+1)'(oldest_q) + (AW+1)'(held_q);
  assign wr_slot  = (slot_sum >= (AW+1)'(MAX_BLUR)) ?
                    AW'(slot_sum - (AW+1)'(MAX_BLUR)) : AW'(slot_sum);

  assign due = flush_q ? (held_q != '0) : (held_q >= eff_len);
  assign rd_en = (state_q == StCheck) && due;
  assign emit_go = (state_q == StEmit) && (!ovalid_q || m_axis_tready);
  assign dshift = SW'(divisor_q) << bit_q;

  hmb_ram #(
    .Width(hmb_pkg::PixelW),
    .Depth(MAX_BLUR)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(wr_slot),
    .wdata_i(in_px),
    .re_i   (rd_en),
    .raddr_i(oldest_q),
    .rdata_o(rd_px)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc) state_d = StCheck;
      StCheck: state_d = due ? StLoad : StIdle;
      StLoad:  state_d = StDiv;
      StDiv:   if (bit_q == 3'd0) state_d = StEmit;
      StEmit:  if (emit_go) state_d = StCheck;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      blur_q   <= hmb_pkg::LenW'(1);
      rsum_q   <= '0;
      gsum_q   <= '0;
      bsum_q   <= '0;
      held_q   <= '0;
      oldest_q <= '0;
      flush_q  <= 1'b0;
      ovalid_q <= 1'b0;
      bit_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        blur_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        // append pixel and add it to the sums
        rsum_q  <= rsum_q + SW'(in_px.red);
        gsum_q  <= gsum_q + SW'(in_px.green);
        bsum_q  <= bsum_q + SW'(in_px.blue);
        held_q  <= held_q + CW'(1);
        flush_q <= s_axis_tlast;
      end
      if (state_q == StLoad) begin
        bit_q <= 3'd7;
      end else if (state_q == StDiv && bit_q != 3'd0) begin
        bit_q <= bit_q - 3'd1;
      end
      if (emit_go) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      if (emit_go) begin
        // drop the oldest pixel and advance
        rsum_q   <= rsum_q - SW'(old_px_q.red);
        gsum_q   <= gsum_q - SW'(old_px_q.green);
        bsum_q   <= bsum_q - SW'(old_px_q.blue);
        held_q   <= held_q - CW'(1);
        oldest_q <= (oldest_q == AW'(MAX_BLUR - 1)) ? '0 : oldest_q + AW'(1);
      end
    end
  end

  // Datapath: capture operands, run restoring division, load output.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rrem_q    <= rsum_q;
      grem_q    <= gsum_q;
      brem_q    <= bsum_q;
      divisor_q <= held_q;
    end
    if (state_q == StLoad) begin
      old_px_q <= rd_px;
      rquo_q   <= '0;
      gquo_q   <= '0;
      bquo_q   <= '0;
    end
    if (state_q == StDiv) begin
      if (rrem_q >= dshift) begin
        rrem_q         <= rrem_q - dshift;
        rquo_q[bit_q]  <= 1'b1;
      end
      if (grem_q >= dshift) begin
        grem_q         <= grem_q - dshift;
        gquo_q[bit_q]  <= 1'b1;
      end
      if (brem_q >= dshift) begin
        brem_q         <= brem_q - dshift;
        bquo_q[bit_q]  <= 1'b1;
      end
    end
    if (emit_go) begin
      odata_q.red   <= rquo_q;
      odata_q.green <= gquo_q;
      odata_q.blue  <= bquo_q;
      olast_q       <= flush_q && (held_q == CW'(1));
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

// ===== tb/horizontal_motion_blur_core_test.sv =====
// Testbench: random and directed pixel rows checked against a forward box blur predictor.
module horizontal_motion_blur_core_test;

  localparam int unsigned MaxBlur = 32;

  typedef struct packed {
    logic       row_end;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } px_item_t;

  typedef struct packed {
    logic       row_last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } blur_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;

  horizontal_motion_blur_core #(.MAX_BLUR(MaxBlur)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_wdata_i
  );

  // Predictor state: window of held pixels and running channel sums.
  hmb_pkg::pixel_t held_px[$];
  int unsigned sum_r, sum_g, sum_b;
  logic [5:0]  blur_len;

  px_item_t   pending_px[$];
  blur_item_t expected_px[$];
  int         errors = 0;
  bit         stall_req;         // asks for one long receiver stall
  bit         hold_off;          // receiver held off by the stall process
  bit         send_paused;

  function automatic int unsigned eff_len(logic [5:0] l);
    if (l == 0) return 1;
    if (l > MaxBlur) return MaxBlur;
    return l;
  endfunction

  task automatic emit_oldest_px(bit last);
    blur_item_t o;
    hmb_pkg::pixel_t p;
    int unsigned n;
    n = held_px.size();
    o.red = 8'(sum_r / n);
    o.green = 8'(sum_g / n);
    o.blue = 8'(sum_b / n);
    o.row_last = last;
    expected_px = {expected_px, o};
    p = held_px.pop_front();
    sum_r -= p.red;
    sum_g -= p.green;
    sum_b -= p.blue;
  endtask

  // Append one accepted pixel and queue every blurred pixel it releases.
  task automatic predict_blur(px_item_t it);
    hmb_pkg::pixel_t p;
    int unsigned len;
    int cnt;
    len = eff_len(blur_len);
    cnt = 0;
    if (held_px.size() >= MaxBlur) begin
      emit_oldest_px(1'b0);
      cnt++;
    end
    p.red = it.red;
    p.green = it.green;
    p.blue = it.blue;
    held_px = {held_px, p};
    sum_r += it.red;
    sum_g += it.green;
    sum_b += it.blue;
    if (it.row_end) begin
      while (held_px.size() > 0 && cnt < MaxBlur) begin
        emit_oldest_px(held_px.size() == 1);
        cnt++;
      end
    end else begin
      while (held_px.size() >= len && cnt < MaxBlur) begin
        emit_oldest_px(1'b0);
        cnt++;
      end
    end
  endtask

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offer queued pixels with random gaps; advance only on handshake.
  int unsigned src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_blur(pending_px.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (src_gap != 0 || send_paused || pending_px.size() == 0) begin
        s_axis_tvalid <= 0;
        if (src_gap != 0) src_gap <= src_gap - 1;
      end else begin
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {pending_px[0].blue, pending_px[0].green, pending_px[0].red};
        s_axis_tlast  <= pending_px[0].row_end;
        src_gap       <= gap_len();
      end
    end
  end

  // Long receiver stall: hold tready low for a fixed stretch once requested.
  initial begin
    hold_off = 0;
    wait (stall_req);
    @(posedge clk_i);
    hold_off <= 1;
    repeat (600) @(posedge clk_i);
    hold_off <= 0;
  end

  // Monitor: random back pressure plus the long stall; check each item.
  int unsigned sink_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    blur_item_t want;
    if (!rst_ni) begin
      m_axis_tready <= 0;
      sink_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected item actual=%h last=%b", $time, m_axis_tdata,
                   m_axis_tlast);
          errors++;
        end else begin
          want = expected_px.pop_front();
          if (m_axis_tdata != {want.blue, want.green, want.red} ||
              m_axis_tlast != want.row_last) begin
            $display("%0t: mismatch expected=%h last=%b actual=%h last=%b", $time,
                     {want.blue, want.green, want.red}, want.row_last,
                     m_axis_tdata, m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold_off) begin
        m_axis_tready <= 0;
      end else if (sink_gap != 0) begin
        m_axis_tready <= 0;
        sink_gap <= sink_gap - 1;
      end else begin
        m_axis_tready <= 1;
        sink_gap <= (m_axis_tready && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  task automatic wait_drained();
    while (pending_px.size() != 0 || s_axis_tvalid || expected_px.size() != 0)
      @(posedge clk_i);
    // let a still-busy engine settle before touching the register
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_len(logic [5:0] l);
    cfg_we_i    <= 1;
    cfg_wdata_i <= l;
    @(posedge clk_i);
    blur_len = l;
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic push_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic e);
    px_item_t it;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.row_end = e;
    pending_px = {pending_px, it};
  endtask

  task automatic push_row(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_px(8'($urandom), 8'($urandom), 8'($urandom), i == n - 1);
  endtask

  logic [5:0] len_choice[8] = '{6'd0, 6'd1, 6'd2, 6'd5, 6'd31, 6'd32, 6'd33, 6'd63};

  initial begin
    int unsigned sent;
    int unsigned n;
    stall_req = 0;
    send_paused = 0;
    blur_len = 1;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: pass-through at reset length, extremes, then zero length.
    push_px(8'h00, 8'h00, 8'h00, 0);
    push_px(8'hFF, 8'hFF, 8'hFF, 1);
    wait_drained();
    write_len(6'd0);
    push_px(8'hAA, 8'h55, 8'hFF, 1);
    wait_drained();
    // Maximum length with a short row of fixed values, then saturated length above the maximum.
    write_len(6'd32);
    for (int i = 0; i < 6; i++) push_px(8'hFF, 8'h01, 8'h80, i == 5);
    wait_drained();
    write_len(6'd63);
    push_px(8'h12, 8'h34, 8'h56, 0);
    push_px(8'hFE, 8'hDC, 8'hBA, 1);
    wait_drained();
    write_len(6'd3);
    for (int i = 0; i < 6; i++) push_px(8'hFF, 8'h00, 8'h7F, i == 5);
    wait_drained();

    // Length shrunk and grown mid-row: the held window stays across the write.
    write_len(6'd8);
    for (int i = 0; i < 5; i++) push_px(8'($urandom), 8'($urandom), 8'($urandom), 0);
    wait_drained();
    write_len(6'd2);
    push_px(8'h10, 8'h20, 8'h30, 0);
    wait_drained();
    write_len(6'd6);
    for (int i = 0; i < 4; i++) push_px(8'($urandom), 8'($urandom), 8'($urandom), i == 3);
    wait_drained();

    // Random rows with random lengths; long receiver stall in the second phase.
    sent = 0;
    for (int ph = 0; sent < 200; ph++) begin
      write_len(ph < 8 ? len_choice[ph] : 6'($urandom));
      if (ph == 1) stall_req = 1;
      for (int r = 0; r < 3 && sent < 200; r++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 12);
        push_row(n);
        sent += n;
      end
      // Row without an end marker: results only come as the window fills.
      if ($urandom_range(0, 1) == 0) begin
        for (int i = 0; i < 3; i++) push_px(8'($urandom), 8'($urandom), 8'($urandom), 0);
        sent += 3;
      end
      if (ph == 2) begin
        // let part of the phase through, then hold the sender until all results are out
        repeat (30) @(posedge clk_i);
        send_paused = 1;
        while (expected_px.size() != 0 || s_axis_tvalid) @(posedge clk_i);
        send_paused = 0;
      end
      wait_drained();
    end
    // Flush whatever is still held.
    push_px(8'($urandom), 8'($urandom), 8'($urandom), 1);
    wait_drained();

    if (errors == 0 && expected_px.size() == 0) begin
      $display("horizontal_motion_blur_core_test: PASS");
    end else begin
      $display("horizontal_motion_blur_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("horizontal_motion_blur_core_test: FAIL");
    $finish;
  end

endmodule
